@@ hdl/lcct_pkg.sv @@
// Package for the lag-compensated countdown timer: item/result types, codes,
// constants and the counted-exposure helper. No dependencies.
package lcct_pkg;

  // Run state codes, also the status field encoding
  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PAUSED  = 2'd2
  } run_state_e;

  // Item kinds; code 7 is unused and ignored
  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_START       = 3'd1,
    KIND_PAUSE       = 3'd2,
    KIND_RESUME      = 3'd3,
    KIND_STOP        = 3'd4,
    KIND_RESET       = 3'd5,
    KIND_RESET_TOTAL = 3'd6
  } kind_e;

  localparam logic [31:0] MS_PER_TENTH  = 32'd100;
  localparam logic [31:0] BEEP_BEGIN_MS = 32'd1000;

  // x / 100 == (x * DIV100_MULT) >> DIV_SHIFT, exact for every 32-bit x
  localparam logic [31:0] DIV100_MULT = 32'd2748779070;
  localparam int unsigned DIV_SHIFT   = 38;
  localparam int unsigned TENTHS_W    = 64 - DIV_SHIFT;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [15:0] duration_tenths;
    logic        beeper_on;
  } item_t;

  typedef struct packed {
    logic        relay_on;
    logic [1:0]  status;
    logic        just_stopped;
    logic        just_finished;
    logic [31:0] left_ms;
    logic        in_lag;
    logic        pause_counted;
    logic        beep_short;
    logic        beeper_begin;
    logic        beeper_end;
  } flags_t;

  // Result before the divide-by-100 stages
  typedef struct packed {
    flags_t      flags;
    logic [31:0] total_ms;
    logic [31:0] last_run_ms;
  } res_t;

  // Final result beat
  typedef struct packed {
    flags_t              flags;
    logic [TENTHS_W-1:0] total_tenths;
    logic [TENTHS_W-1:0] last_run_tenths;
  } out_t;

  // Exposure counted so far in the current run (0 unless running)
  function automatic logic [31:0] counted_ms(
    input logic        running,
    input logic [31:0] clk_ms,
    input logic [31:0] res_ms,
    input logic [31:0] rem_ms,
    input logic [31:0] lag_ms
  );
    logic [31:0] stop_ms;
    logic [31:0] since_ms;
    logic [31:0] cnt;
    stop_ms  = res_ms + rem_ms + lag_ms;
    since_ms = clk_ms - res_ms;
    if (!running) begin
      cnt = '0;
    end else if (clk_ms > stop_ms) begin
      cnt = rem_ms;
    end else if (since_ms < lag_ms) begin
      cnt = '0;
    end else begin
      cnt = since_ms - lag_ms;
    end
    return cnt;
  endfunction

endpackage

@@ hdl/lag_compensated_countdown_timer_unit.sv @@
// Top level of the lag-compensated countdown timer: input register, state
// update core, divide stages, ports. Depends on lcct_pkg, lcct_core, lcct_div100.
//
//  channel | signals                              | direction | flow control
//  --------+--------------------------------------+-----------+-------------
//  in      | in_valid_i, in_stall_o, in_*_i        | sink      | valid/stall
//  out     | out_valid_o, out_stall_i, *_o fields  | source    | valid/stall
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_lag_ms_i| sink      | valid/ready
//
// One item per clock sustained while out_stall_i is low. Rate is set by the
// state update loop in the core (input register -> update logic -> result
// register), followed by a product register and an output register for the
// divide by 100; out_valid_o rises once an accepted item has passed through
// all of these registers.
// Reset (rst_ni low, async) clears the timer state, lag_ms and all valids.
// out_stall_i holds the output beat; bubbles in the pipe still absorb new
// input, so in_stall_o rises only once every stage is full.
module lag_compensated_countdown_timer_unit import lcct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_kind_i,
  input  logic [31:0] in_now_ms_i,
  input  logic [15:0] in_duration_tenths_i,
  input  logic        in_beeper_on_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        relay_on_o,
  output logic [1:0]  status_o,
  output logic        just_stopped_o,
  output logic        just_finished_o,
  output logic [31:0] left_ms_o,
  output logic [25:0] total_tenths_o,
  output logic [25:0] last_run_tenths_o,
  output logic        in_lag_o,
  output logic        pause_counted_o,
  output logic        beep_short_o,
  output logic        beeper_begin_o,
  output logic        beeper_end_o,
  // lag register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_lag_ms_i
);

  logic [15:0] lag_q;
  logic        v0_q, v1_q;
  item_t       item_q;
  logic        ready0, ready1;
  logic        div_ready;
  logic        step;
  res_t        res;
  out_t        out_beat;

  // Lag register: writes only arrive while the pipe is idle is a rule for the user; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lag_q <= cfg_lag_ms_i;
    end
  end

  // Stage 0 is the input register, stage 1 the core's result register
  assign ready1     = !v1_q || div_ready;
  assign ready0     = !v0_q || ready1;
  assign in_stall_o = !ready0;
  assign step       = v0_q && ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (ready0) v0_q <= in_valid_i;
      if (ready1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0 && in_valid_i) begin
      item_q.kind            <= in_kind_i;
      item_q.now_ms          <= in_now_ms_i;
      item_q.duration_tenths <= in_duration_tenths_i;
      item_q.beeper_on       <= in_beeper_on_i;
    end
  end

  lcct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .lag_ms_i (lag_q),
    .res_o    (res)
  );

  lcct_div100 u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (div_ready),
    .in_res_i    (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_beat)
  );

  assign relay_on_o        = out_beat.flags.relay_on;
  assign status_o          = out_beat.flags.status;
  assign just_stopped_o    = out_beat.flags.just_stopped;
  assign just_finished_o   = out_beat.flags.just_finished;
  assign left_ms_o         = out_beat.flags.left_ms;
  assign total_tenths_o    = out_beat.total_tenths;
  assign last_run_tenths_o = out_beat.last_run_tenths;
  assign in_lag_o          = out_beat.flags.in_lag;
  assign pause_counted_o   = out_beat.flags.pause_counted;
  assign beep_short_o      = out_beat.flags.beep_short;
  assign beeper_begin_o    = out_beat.flags.beeper_begin;
  assign beeper_end_o      = out_beat.flags.beeper_end;

  // Relay follows the running state
  a_relay_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (relay_on_o == (status_o == ST_RUNNING)))
    else $error("relay_on disagrees with status");

  // Lag window only exists while running
  a_lag_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_lag_o) |-> relay_on_o)
    else $error("in_lag set while not running");

  // A beat never both starts and stops the continuous beeper
  a_beeper_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(beeper_begin_o && beeper_end_o))
    else $error("beeper begin and end in one beat");

  // A counted pause leaves the timer paused with the beeper stopped
  a_pause_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pause_counted_o) |-> (beeper_end_o && status_o == ST_PAUSED))
    else $error("pause_counted without an accepted pause");

endmodule

@@ hdl/lcct_core.sv @@
// Timer state registers and the single-pass update for one item.
// Depends on lcct_pkg.
module lcct_core import lcct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,   // item in item_i executes this edge
  input  item_t       item_i,
  input  logic [15:0] lag_ms_i,
  output res_t        res_o
);

  run_state_e  rs_q, rs_d;
  logic [31:0] clock_q, clock_d;
  logic [31:0] resume_q, resume_d;
  logic [31:0] remaining_q, remaining_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] last_q, last_d;
  logic        stopped_q, stopped_d;
  logic        finished_q, finished_d;
  res_t        res_q, res_d;

  logic [31:0] lag32;
  logic [31:0] clk_eff;
  logic [31:0] stop_cur;
  logic [31:0] c_cur;
  logic        reached;
  logic [31:0] rem_start;
  logic [31:0] c_start;
  logic [31:0] c_new;
  logic        running_new;
  logic        beep, begin_cmd, end_cmd, pcount;

  assign lag32     = {16'd0, lag_ms_i};
  assign clk_eff   = (item_i.kind == KIND_TICK) ? item_i.now_ms : clock_q;
  assign stop_cur  = resume_q + remaining_q + lag32;
  assign c_cur     = counted_ms(rs_q == ST_RUNNING, clk_eff, resume_q, remaining_q, lag32);
  assign reached   = (clk_eff >= stop_cur);
  assign rem_start = 32'({16'd0, item_i.duration_tenths} * MS_PER_TENTH);
  assign c_start   = counted_ms(1'b1, clock_q, clock_q, rem_start, lag32);

  always_comb begin
    rs_d        = rs_q;
    clock_d     = clock_q;
    resume_d    = resume_q;
    remaining_d = remaining_q;
    acc_d       = acc_q;
    last_d      = last_q;
    stopped_d   = stopped_q;
    finished_d  = finished_q;
    beep        = 1'b0;
    begin_cmd   = 1'b0;
    end_cmd     = 1'b0;
    pcount      = 1'b0;

    case (item_i.kind)
      KIND_TICK: begin
        clock_d    = item_i.now_ms;
        stopped_d  = 1'b0;
        finished_d = 1'b0;
        if (rs_q == ST_RUNNING) begin
          if (c_cur != '0) last_d = c_cur;
          if (reached) begin
            finished_d  = 1'b1;
            stopped_d   = 1'b1;
            end_cmd     = 1'b1;
            acc_d       = acc_q + remaining_q;
            rs_d        = ST_STOPPED;
            remaining_d = '0;
          end else begin
            begin_cmd = !item_i.beeper_on && (c_cur >= BEEP_BEGIN_MS);
          end
        end
      end
      KIND_START: begin
        beep = 1'b1;
        if (item_i.duration_tenths == '0) begin
          finished_d = 1'b1;
          stopped_d  = 1'b1;
        end else begin
          remaining_d = rem_start;
          resume_d    = clock_q;
          rs_d        = ST_RUNNING;
          if (c_start != '0) last_d = c_start;
        end
      end
      KIND_PAUSE: begin
        if (rs_q == ST_RUNNING) begin
          end_cmd     = 1'b1;
          if (c_cur != '0) last_d = c_cur;
          acc_d       = acc_q + c_cur;
          remaining_d = remaining_q - c_cur;
          rs_d        = ST_PAUSED;
          pcount      = clock_q > (resume_q + lag32);
        end
      end
      KIND_RESUME: begin
        if (rs_q == ST_PAUSED) begin
          beep     = 1'b1;
          resume_d = clock_q;
          rs_d     = ST_RUNNING;
        end
      end
      KIND_STOP, KIND_RESET: begin
        end_cmd = 1'b1;
        if (rs_q != ST_STOPPED) begin
          stopped_d   = 1'b1;
          if (c_cur != '0) last_d = c_cur;
          acc_d       = acc_q + (reached ? remaining_q : c_cur);
          rs_d        = ST_STOPPED;
          remaining_d = '0;
        end
        if (item_i.kind == KIND_RESET) begin
          acc_d  = '0;
          last_d = '0;
        end
      end
      KIND_RESET_TOTAL: begin
        acc_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Report on the state after the item
  assign running_new = (rs_d == ST_RUNNING);
  assign c_new       = counted_ms(running_new, clock_d, resume_d, remaining_d, lag32);

  always_comb begin
    res_d                     = '0;
    res_d.flags.relay_on      = running_new;
    res_d.flags.status        = rs_d;
    res_d.flags.just_stopped  = stopped_d;
    res_d.flags.just_finished = finished_d;
    res_d.flags.left_ms       = (running_new && c_new != '0)
                                ? (resume_d + remaining_d + lag32 - clock_d) : remaining_d;
    res_d.flags.in_lag        = running_new && (c_new == '0);
    res_d.flags.pause_counted = pcount;
    res_d.flags.beep_short    = beep;
    res_d.flags.beeper_begin  = begin_cmd;
    res_d.flags.beeper_end    = end_cmd;
    res_d.total_ms            = acc_d + c_new;
    res_d.last_run_ms         = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q        <= ST_STOPPED;
      clock_q     <= '0;
      resume_q    <= '0;
      remaining_q <= '0;
      acc_q       <= '0;
      last_q      <= '0;
      stopped_q   <= 1'b0;
      finished_q  <= 1'b0;
    end else if (step_i) begin
      rs_q        <= rs_d;
      clock_q     <= clock_d;
      resume_q    <= resume_d;
      remaining_q <= remaining_d;
      acc_q       <= acc_d;
      last_q      <= last_d;
      stopped_q   <= stopped_d;
      finished_q  <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/lcct_div100.sv @@
// Two-stage divide-by-100 of the total and last-run sums by reciprocal
// multiply, with its own valid/stall flow control. Depends on lcct_pkg.
module lcct_div100 import lcct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_res_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic        v2_q, v3_q;
  logic        ready2, ready3;
  flags_t      flags2_q;
  logic [63:0] prod_tot_q, prod_last_q;
  out_t        out_q;

  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign in_ready_o = ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready2) v2_q <= in_valid_i;
      if (ready3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && in_valid_i) begin
      flags2_q    <= in_res_i.flags;
      prod_tot_q  <= {32'd0, in_res_i.total_ms} * {32'd0, DIV100_MULT};
      prod_last_q <= {32'd0, in_res_i.last_run_ms} * {32'd0, DIV100_MULT};
    end
    if (ready3 && v2_q) begin
      out_q.flags           <= flags2_q;
      out_q.total_tenths    <= prod_tot_q[63:DIV_SHIFT];
      out_q.last_run_tenths <= prod_last_q[63:DIV_SHIFT];
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule
